/* sv/fats_pkg.sv */
// fats_pkg: shared types and constants of the fault address table search block
// codes for the item action, register decode, state machine and result beat
// no dependencies
package fats_pkg;

	// default table depth
	localparam int TABLE_DEPTH_DEF = 1024;

	// field widths of the item and result beats and of the entry count
	localparam int INDEX_W = 10;
	localparam int KEY_W   = 32;
	localparam int FADDR_W = 64;
	localparam int COUNT_W = 11;

	// configuration port widths
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;

	// item action codes
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// register select, taken from paddr bit 3
	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_BASE_OFFSET = 1'b1;

	// search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// one result beat
	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] match_index;
	} res_t;

endpackage

/* sv/fats_if.sv */
// fats_if: valid/ready channels for item beats and result beats
// depends on fats_pkg for field widths
interface fats_item_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [fats_pkg::INDEX_W-1:0]  entry_index;
	logic signed [fats_pkg::KEY_W-1:0] entry_key;
	logic [fats_pkg::FADDR_W-1:0]  fault_address;

	modport source(output valid, output action, output entry_index, output entry_key,
		output fault_address, input ready);
	modport sink(input valid, input action, input entry_index, input entry_key,
		input fault_address, output ready);
endinterface

interface fats_result_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [fats_pkg::INDEX_W-1:0] match_index;

	modport source(output valid, output found, output match_index, input ready);
	modport sink(input valid, input found, input match_index, output ready);
endinterface

/* sv/fats_key_mem.sv */
// fats_key_mem: key table, one write port and one registered read port
// no package dependencies
module fats_key_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/fats_search_ctl.sv */
// fats_search_ctl: item intake, range check and binary search sequencer
// one probe per cycle against the key memory; depends on fats_pkg, fats_if
module fats_search_ctl #(
	parameter int TABLE_DEPTH = fats_pkg::TABLE_DEPTH_DEF,
	parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fats_item_if.sink                     item,
	input  logic [fats_pkg::COUNT_W-1:0]  entry_count,
	input  logic [fats_pkg::FADDR_W-1:0]  base_offset,
	output logic                          res_valid,
	input  logic                          res_ready,
	output fats_pkg::res_t                res,
	output logic                          mem_wr_en,
	output logic [AW-1:0]                 mem_wr_addr,
	output logic [fats_pkg::KEY_W-1:0]    mem_wr_data,
	output logic                          mem_rd_en,
	output logic [AW-1:0]                 mem_rd_addr,
	input  logic [fats_pkg::KEY_W-1:0]    mem_rd_data
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	fats_pkg::state_t state_q, state_nx;

	logic [fats_pkg::FADDR_W-1:0] addr_q;
	logic [fats_pkg::KEY_W-1:0]   value_q;
	logic [CW-1:0]                lo_q, end_q, mid_q;
	fats_pkg::res_t               res_q;

	logic                         accept;
	logic [fats_pkg::FADDR_W-1:0] diff;
	logic                         in_range;
	logic [31:0]                  cnt_ext;
	logic [CW-1:0]                n_sat;
	logic                         hit, less;
	logic [CW-1:0]                lo_nx, end_nx, mid_nx;
	logic [CW:0]                  mid_sum;
	logic                         go;
	logic [31:0]                  mid_ext;

	assign accept = item.valid && item.ready;

	// offset subtraction and signed 32-bit range check
	assign diff     = addr_q - base_offset;
	assign in_range = (diff[63:31] == '0) || (diff[63:31] == '1);

	// count clamped to the table depth
	assign cnt_ext = 32'(entry_count);
	assign n_sat   = (cnt_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

	// probe compare
	assign hit  = (mem_rd_data == value_q);
	assign less = ($signed(mem_rd_data) < $signed(value_q));

	// next search window, end is exclusive
	always_comb begin
		lo_nx  = '0;
		end_nx = n_sat;
		if (state_q == fats_pkg::ST_SEARCH) begin
			lo_nx  = less ? CW'(mid_q + 1'b1) : lo_q;
			end_nx = less ? end_q : mid_q;
		end
	end

	assign go      = (lo_nx < end_nx);
	assign mid_sum = {1'b0, lo_nx} + {1'b0, end_nx} - 1'b1;
	assign mid_nx  = mid_sum[CW:1];
	assign mid_ext = 32'(mid_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fats_pkg::ST_IDLE: begin
				if (accept && item.action == fats_pkg::ACT_SEARCH) begin
					state_nx = fats_pkg::ST_CHECK;
				end
			end
			fats_pkg::ST_CHECK: begin
				state_nx = (in_range && go) ? fats_pkg::ST_SEARCH : fats_pkg::ST_FINISH;
			end
			fats_pkg::ST_SEARCH: begin
				state_nx = (!hit && go) ? fats_pkg::ST_SEARCH : fats_pkg::ST_FINISH;
			end
			fats_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_nx = fats_pkg::ST_IDLE;
				end
			end
			default: state_nx = fats_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready  = (state_q == fats_pkg::ST_IDLE);
		res_valid   = (state_q == fats_pkg::ST_FINISH);
		mem_wr_en   = accept && (item.action == fats_pkg::ACT_LOAD)
			&& (32'(item.entry_index) < 32'(TABLE_DEPTH));
		mem_wr_addr = AW'(item.entry_index);
		mem_wr_data = item.entry_key;
		mem_rd_addr = AW'(mid_nx);
		mem_rd_en   = 1'b0;
		unique case (state_q)
			fats_pkg::ST_CHECK:  mem_rd_en = in_range && go;
			fats_pkg::ST_SEARCH: mem_rd_en = !hit && go;
			fats_pkg::ST_IDLE,
			fats_pkg::ST_FINISH: mem_rd_en = 1'b0;
			default:             mem_rd_en = 1'b0;
		endcase
	end

	assign res = res_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fats_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// search datapath registers
	always_ff @(posedge clk) begin
		if (state_q == fats_pkg::ST_IDLE && accept) begin
			addr_q <= item.fault_address;
		end
		if (state_q == fats_pkg::ST_CHECK) begin
			value_q <= diff[31:0];
		end
		if (state_q == fats_pkg::ST_CHECK || state_q == fats_pkg::ST_SEARCH) begin
			lo_q  <= lo_nx;
			end_q <= end_nx;
			mid_q <= mid_nx;
		end
		// result capture
		if (state_q == fats_pkg::ST_CHECK && !(in_range && go)) begin
			res_q <= '0;
		end else if (state_q == fats_pkg::ST_SEARCH) begin
			if (hit) begin
				res_q.found       <= 1'b1;
				res_q.match_index <= mid_ext[fats_pkg::INDEX_W-1:0];
			end else if (!go) begin
				res_q <= '0;
			end
		end
	end

endmodule

/* sv/fault_address_table_search_top.sv */
// fault_address_table_search_top: a search result reaches the output register after the range check
// and its probes, at most floor(log2(count)) + 1 probes (11 at 1024)
// one item at a time: next item taken the cycle after the result moves into the output register
// out-of-range offset or zero count skips the probes; each probe is one key memory read
// reset clears control, entry_count and base_offset; the key table holds no reset value
// depends on fats_pkg, fats_if, fats_key_mem, fats_search_ctl
module fault_address_table_search_top #(
	parameter int TABLE_DEPTH = fats_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fats_item_if.sink                    item,
	fats_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fats_pkg::APB_AW-1:0]  paddr,
	input  logic [fats_pkg::APB_DW-1:0]  pwdata,
	output logic [fats_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [fats_pkg::COUNT_W-1:0] count_q;
	logic [fats_pkg::FADDR_W-1:0] base_q;
	logic                         cfg_wr;

	logic                  res_valid, res_ready;
	fats_pkg::res_t        res;
	logic                  out_valid_q;
	fats_pkg::res_t        out_res_q;

	logic                         mem_wr_en, mem_rd_en;
	logic [AW-1:0]                mem_wr_addr, mem_rd_addr;
	logic [fats_pkg::KEY_W-1:0]   mem_wr_data, mem_rd_data;

	// register write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				fats_pkg::REG_ENTRY_COUNT: count_q <= pwdata[fats_pkg::COUNT_W-1:0];
				fats_pkg::REG_BASE_OFFSET: base_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			fats_pkg::REG_ENTRY_COUNT: prdata = fats_pkg::APB_DW'(count_q);
			fats_pkg::REG_BASE_OFFSET: prdata = base_q;
			default:                   prdata = '0;
		endcase
	end

	// search sequencer
	fats_search_ctl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.entry_count(count_q),
		.base_offset(base_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	// key table
	fats_key_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW),
		.DW(fats_pkg::KEY_W)
	) u_mem (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// result output register
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = out_res_q.found;
	assign result.match_index = out_res_q.match_index;

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for fault_address_table_search_top
// drives load and search beats plus apb register writes, predicts each search result
// depends on fats_pkg, fats_if and the rtl of fault_address_table_search_top
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH     = fats_pkg::TABLE_DEPTH_DEF;
	localparam int CLK_PERIOD      = 12;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 42;

	// first probes of a full-depth search; with the key maximum at both of them and at
	// the end of the loaded prefix, every search stays inside written entries
	localparam int MID0       = (TABLE_DEPTH - 1) / 2;
	localparam int MID1       = (MID0 - 1) / 2;
	localparam int FILL_DEPTH = (MID1 - 1) / 2 + 1;

	localparam logic [fats_pkg::APB_AW-1:0] ADDR_ENTRY_COUNT =
		{fats_pkg::REG_ENTRY_COUNT, 3'b000};
	localparam logic [fats_pkg::APB_AW-1:0] ADDR_BASE_OFFSET =
		{fats_pkg::REG_BASE_OFFSET, 3'b000};

	// shadow of the key table and registers, with the lookups still owed
	class table_scoreboard;
		logic signed [fats_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
		int unsigned                       entry_count;
		logic [fats_pkg::FADDR_W-1:0]      base_offset;
		fats_pkg::res_t                    pending_lookups [$];
		int                                errors;

		function new();
			entry_count = 0;
			base_offset = '0;
			errors = 0;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10) $display("%s", what);
		endfunction

		// binary search over the shadow table, midpoint rounded down
		function fats_pkg::res_t lookup_fault(logic [fats_pkg::FADDR_W-1:0] addr);
			logic [fats_pkg::FADDR_W-1:0] diff;
			logic [fats_pkg::FADDR_W-1:0] biased;
			logic signed [fats_pkg::KEY_W-1:0] value;
			int n;
			int lo;
			int hi;
			int mid;
			fats_pkg::res_t r;
			r = '0;
			diff = addr - base_offset;
			biased = diff + 64'h0000_0000_8000_0000;
			// difference outside signed 32 bits
			if (biased > 64'h0000_0000_FFFF_FFFF) return r;
			value = diff[fats_pkg::KEY_W-1:0];
			n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (keys[mid] == value) begin
					r.found = 1'b1;
					r.match_index = mid[fats_pkg::INDEX_W-1:0];
					return r;
				end else if (keys[mid] < value) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return r;
		endfunction

		function void set_reg(logic [fats_pkg::APB_AW-1:0] addr,
				logic [fats_pkg::APB_DW-1:0] data);
			case (addr[3])
				fats_pkg::REG_ENTRY_COUNT: entry_count = 32'(data[fats_pkg::COUNT_W-1:0]);
				fats_pkg::REG_BASE_OFFSET: base_offset = data;
			endcase
		endfunction

		function void note_item(logic act, logic [fats_pkg::INDEX_W-1:0] idx,
				logic signed [fats_pkg::KEY_W-1:0] key, logic [fats_pkg::FADDR_W-1:0] addr);
			if (act == fats_pkg::ACT_LOAD) begin
				keys[idx] = key;
			end else begin
				pending_lookups.push_back(lookup_fault(addr));
			end
		endfunction

		function void check_result(logic found, logic [fats_pkg::INDEX_W-1:0] match_index);
			fats_pkg::res_t want;
			if (pending_lookups.size() == 0) begin
				flag($sformatf("unexpected result beat: found=%0b index=%0d",
					found, match_index));
				return;
			end
			want = pending_lookups.pop_front();
			if (want.found !== found || want.match_index !== match_index)
				flag($sformatf({"lookup mismatch: expected found=%0b index=%0d, ",
					"got found=%0b index=%0d"},
					want.found, want.match_index, found, match_index));
		endfunction

		function void close_out();
			if (pending_lookups.size() != 0)
				flag($sformatf("%0d lookups never answered", pending_lookups.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [fats_pkg::APB_AW-1:0] paddr;
	logic [fats_pkg::APB_DW-1:0] pwdata;
	logic [fats_pkg::APB_DW-1:0] prdata;
	logic pready;
	bit no_idle = 1'b0;

	table_scoreboard sb;

	fats_item_if   item_bus();
	fats_result_if result_bus();

	fault_address_table_search_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit take_break();
		return !no_idle && ($urandom_range(0, 99) < 17);
	endfunction

	// result side stalls at random
	always @(negedge clk) begin
		result_bus.ready <= !take_break();
	end

	// result beats against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			sb.check_result(result_bus.found, result_bus.match_index);
	end

	// one item beat, called at a falling edge, returns at a falling edge
	task automatic send_beat(input logic act, input logic [fats_pkg::INDEX_W-1:0] idx,
			input logic [fats_pkg::KEY_W-1:0] key, input logic [fats_pkg::FADDR_W-1:0] addr);
		while (take_break()) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid         <= 1'b1;
		item_bus.action        <= act;
		item_bus.entry_index   <= idx;
		item_bus.entry_key     <= key;
		item_bus.fault_address <= addr;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		sb.note_item(act, idx, key, addr);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [fats_pkg::INDEX_W-1:0] idx,
			input logic [fats_pkg::KEY_W-1:0] key);
		send_beat(fats_pkg::ACT_LOAD, idx, key, {$urandom, $urandom});
	endtask

	task automatic lookup(input logic [fats_pkg::FADDR_W-1:0] addr);
		send_beat(fats_pkg::ACT_SEARCH, fats_pkg::INDEX_W'($urandom), $urandom, addr);
	endtask

	// apb write: setup then access, called at a falling edge
	task automatic write_reg(input logic [fats_pkg::APB_AW-1:0] addr,
			input logic [fats_pkg::APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(addr, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stop sending, drain every lookup, let a trailing load finish
	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// key strictly between the neighbors so the table stays sorted
	function automatic logic [fats_pkg::KEY_W-1:0] sorted_key_for(int unsigned i);
		longint below;
		longint above;
		longint span;
		longint pick;
		below = (i == 0) ? -64'sd2147483649 : longint'(sb.keys[i-1]);
		above = (i == TABLE_DEPTH - 1) ? 64'sd2147483648 : longint'(sb.keys[i+1]);
		span = above - below - 1;
		if (span < 1) return sb.keys[i];
		pick = below + 1 + (longint'({32'd0, $urandom}) % span);
		return pick[fats_pkg::KEY_W-1:0];
	endfunction

	// search address: hits, near misses, range edges, wide noise
	// candidate keys come from the loaded prefix
	function automatic logic [fats_pkg::FADDR_W-1:0] pick_address();
		int n;
		int pick;
		logic signed [fats_pkg::KEY_W-1:0] k;
		logic [fats_pkg::FADDR_W-1:0] v;
		n = (sb.entry_count > FILL_DEPTH) ? FILL_DEPTH : sb.entry_count;
		pick = $urandom_range(0, 99);
		if (n > 0 && pick < 45) begin
			k = sb.keys[$urandom_range(0, n - 1)];
			v = {{32{k[31]}}, k};
		end else if (n > 0 && pick < 70) begin
			k = sb.keys[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
			v = {{32{k[31]}}, k};
		end else if (pick < 80) begin
			v = {$urandom, $urandom};
		end else if (pick < 90) begin
			case ($urandom_range(0, 3))
				0: v = 64'h0000_0000_7FFF_FFFF;
				1: v = 64'hFFFF_FFFF_8000_0000;
				2: v = 64'h0000_0000_8000_0000;
				default: v = 64'hFFFF_FFFF_7FFF_FFFF;
			endcase
		end else begin
			k = $urandom;
			v = {{32{k[31]}}, k};
		end
		return v + sb.base_offset;
	endfunction

	// run limit
	initial begin
		#(10_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		longint acc;
		logic [fats_pkg::INDEX_W-1:0] idx;
		logic [fats_pkg::APB_DW-1:0] cnt;
		logic [fats_pkg::APB_DW-1:0] base;
		sb = new();
		arst_n                 = 1'b0;
		item_bus.valid         = 1'b0;
		item_bus.action        = fats_pkg::ACT_LOAD;
		item_bus.entry_index   = '0;
		item_bus.entry_key     = '0;
		item_bus.fault_address = '0;
		result_bus.ready       = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: nothing can match
		write_reg(ADDR_ENTRY_COUNT, 64'd0);
		write_reg(ADDR_BASE_OFFSET, 64'd0);
		lookup(64'h0);
		lookup(64'hFFFF_FFFF_FFFF_FFFF);

		// small sorted table with both key extremes
		load_entry(10'd0, 32'h8000_0000);
		load_entry(10'd1, -32'sd1000);
		load_entry(10'd2, -32'sd1);
		load_entry(10'd3, 32'sd0);
		load_entry(10'd4, 32'sd1);
		load_entry(10'd5, 32'sd77);
		load_entry(10'd6, 32'sd1000);
		load_entry(10'd7, 32'h7FFF_FFFF);
		settle();
		write_reg(ADDR_ENTRY_COUNT, 64'd8);
		lookup(64'hFFFF_FFFF_8000_0000);
		lookup(64'h0000_0000_7FFF_FFFF);
		lookup(64'h0);
		lookup(64'd77);
		lookup(64'd5);
		lookup(64'h0000_0000_8000_0000);
		lookup(64'hFFFF_FFFF_7FFF_FFFF);
		lookup(64'hFFFF_FFFF_FFFF_FFFF);

		// offset wraps the subtraction around 2^64
		settle();
		write_reg(ADDR_BASE_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
		lookup(64'd76);
		lookup(64'h0000_0000_7FFF_FFFE);

		// out-of-order entry: search follows the same probes
		load_entry(10'd3, 32'sd5000);
		lookup(64'd4999);
		lookup(64'd0);
		settle();

		// ascending prefix ending at the key maximum, plus the maximum at the
		// first two full-depth probes
		acc = -64'sd2147483648;
		for (int i = 0; i < FILL_DEPTH; i++) begin
			if (i == FILL_DEPTH - 1) acc = 64'sd2147483647;
			else if (i > 0) acc = acc + $urandom_range(1, 30_000_000);
			load_entry(i[fats_pkg::INDEX_W-1:0], acc[fats_pkg::KEY_W-1:0]);
		end
		load_entry(fats_pkg::INDEX_W'(MID1), 32'h7FFF_FFFF);
		load_entry(fats_pkg::INDEX_W'(MID0), 32'h7FFF_FFFF);
		settle();

		// random phases, registers rewritten while idle
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					cnt = 64'(TABLE_DEPTH);
					base = '0;
				end
				1: begin
					cnt = 64'd1;
					base = {$urandom, $urandom};
				end
				2: begin
					cnt = 64'h7FF;
					base = 64'hFFFF_FFFF_FFFF_FFFF;
				end
				3: begin
					cnt = 64'($urandom_range(1, FILL_DEPTH));
					base = {$urandom, $urandom};
					no_idle = 1'b1;
				end
				4: begin
					cnt = 64'd2;
					base = '0;
				end
				5: begin
					cnt = 64'($urandom_range(1, FILL_DEPTH));
					base = 64'h0000_0000_8000_0000;
				end
				default: begin
					cnt = 64'd0;
					base = {$urandom, $urandom};
				end
			endcase
			write_reg(ADDR_ENTRY_COUNT, cnt);
			write_reg(ADDR_BASE_OFFSET, base);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					lookup(pick_address());
				end else begin
					// the prefix end keeps its maximum key
					idx = fats_pkg::INDEX_W'($urandom_range(0, FILL_DEPTH - 2));
					// mostly order-keeping rewrites, now and then a stray key
					if ($urandom_range(0, 9) == 0) load_entry(idx, $urandom);
					else load_entry(idx, sorted_key_for(idx));
				end
			end
			settle();
			no_idle = 1'b0;
		end

		sb.close_out();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
sv/fats_pkg.sv
sv/fats_if.sv
sv/fats_key_mem.sv
sv/fats_search_ctl.sv
sv/fault_address_table_search_top.sv
dv/testbench.sv
